// File: design/imu_frame_parser_with_resync_assert.svh
// Assertion macros used by the frame parser datapath.
// Each macro expects clk and arst_n to exist in the module that uses it.
`ifndef IMU_FRAME_PARSER_WITH_RESYNC_ASSERT_SVH
`define IMU_FRAME_PARSER_WITH_RESYNC_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define IFP_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("frame parser assertion failed");

`define IFP_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame parser assertion failed");

`define IFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame parser assertion failed");

`else

`define IFP_ASSERT_ALWAYS(lbl, cond)
`define IFP_ASSERT_IMPLY(lbl, ante, cons)
`define IFP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: design/ifp_pkg.sv
package ifp_pkg;

	localparam int FRAME_LEN            = 11;
	localparam int KIND_COUNT           = 5;
	localparam int FILL_W               = $clog2(FRAME_LEN + 1);
	localparam int IDX_W                = $clog2(FRAME_LEN);
	localparam int COUNTER_BITS_DEFAULT = 16;
	localparam int OUT_COUNT_W          = 16;

	localparam logic [7:0] HEADER_RESET    = 8'h55;
	localparam logic [7:0] TYPE_BASE_RESET = 8'h50;

	// Register index as decoded from the word address.
	localparam logic REG_HEADER    = 1'b0;
	localparam logic REG_TYPE_BASE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_DECODED     = 2'd0,
		STATUS_UNSUPPORTED = 2'd1,
		STATUS_BAD_SUM     = 2'd2
	} status_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DECIDE,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		logic accept;
		logic sum_step;
		logic decide;
		logic shift;
	} cmd_t;

	typedef struct packed {
		logic completes;
		logic sum_last;
		logic out_free;
		logic bad_sum;
		logic shift_done;
	} stat_t;

endpackage

// File: design/imu_frame_parser_with_resync.sv
// Serial frame parser with checksum check and resynchronisation.
// Bytes arrive on the input channel (in_valid, in_stall, rx_byte). Each
// request carries one received byte. Bytes are dropped until the header
// byte is seen; the next ten bytes complete an eleven-byte frame.
// A byte that does not complete a frame is taken in the idle state and gives
// no result. A completing byte starts a checksum scan over the ten leading
// bytes, one byte per cycle through a single adder; out_valid rises from the
// decision state that follows the scan, once the output register is free.
// After a checksum error the buffer is shifted down one place per cycle
// until a header byte sits at the front or the buffer is empty, which takes
// at most eleven shifts. A completing byte thus occupies the block through
// the scan, the decision and any shifts, plus any wait for the output
// register; in_stall is high throughout.
// Each result is one request on the output channel (out_valid, out_stall
// and the result fields) held in an output register. While the receiver
// stalls, the result holds and bytes that do not complete a frame are
// still taken; a following result waits until the register is free.
// Reset empties the buffer, clears the kind mask and the three counters,
// and restores the header byte and type base registers to their defaults.
// Registers are set through the APB port, header at 0 and type base at 4.
module imu_frame_parser_with_resync
	import ifp_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             rx_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [7:0]             type_byte,
	output logic [2:0]             frame_kind,
	output logic [15:0]            word_x,
	output logic [15:0]            word_y,
	output logic [15:0]            word_z,
	output logic [15:0]            word_extra,
	output logic [KIND_COUNT-1:0]  seen_mask,
	output logic [OUT_COUNT_W-1:0] good_count,
	output logic [OUT_COUNT_W-1:0] unsupported_count,
	output logic [OUT_COUNT_W-1:0] bad_sum_count
);

	logic [7:0] header_q;
	logic [7:0] type_base_q;
	logic       reg_index;
	logic       cfg_write;
	cmd_t       cmd;
	stat_t      stat;

	// The register index is the word address; the byte offset is ignored.
	assign reg_index = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q    <= HEADER_RESET;
			type_base_q <= TYPE_BASE_RESET;
		end else if (cfg_write) begin
			unique case (reg_index)
				REG_HEADER:    header_q    <= pwdata[7:0];
				REG_TYPE_BASE: type_base_q <= pwdata[7:0];
				default:       header_q    <= header_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_HEADER:    prdata = {24'd0, header_q};
			REG_TYPE_BASE: prdata = {24'd0, type_base_q};
			default:       prdata = '0;
		endcase
	end

	// The controller sequences each completed frame through the checksum
	// scan, the decision and, after an error, the realignment shifts.
	ifp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the frame buffer, the sum, the counters and the
	// output register.
	ifp_dp #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.rx_byte           (rx_byte),
		.header_byte       (header_q),
		.type_base         (type_base_q),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.type_byte         (type_byte),
		.frame_kind        (frame_kind),
		.word_x            (word_x),
		.word_y            (word_y),
		.word_z            (word_z),
		.word_extra        (word_extra),
		.seen_mask         (seen_mask),
		.good_count        (good_count),
		.unsupported_count (unsupported_count),
		.bad_sum_count     (bad_sum_count)
	);

endmodule

// File: design/ifp_ctrl.sv
module ifp_ctrl
	import ifp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && stat.completes) begin
					state_next = ST_SUM;
				end
			end
			ST_SUM: begin
				if (stat.sum_last) begin
					state_next = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (stat.out_free) begin
					state_next = stat.bad_sum ? ST_SHIFT : ST_IDLE;
				end
			end
			ST_SHIFT: begin
				if (stat.shift_done) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
			end
			ST_DECIDE: begin
				cmd.decide = stat.out_free;
			end
			ST_SHIFT: begin
				cmd.shift = !stat.shift_done;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// File: design/ifp_dp.sv
`include "imu_frame_parser_with_resync_assert.svh"

module ifp_dp
	import ifp_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic [7:0]             rx_byte,
	input  logic [7:0]             header_byte,
	input  logic [7:0]             type_base,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [7:0]             type_byte,
	output logic [2:0]             frame_kind,
	output logic [15:0]            word_x,
	output logic [15:0]            word_y,
	output logic [15:0]            word_z,
	output logic [15:0]            word_extra,
	output logic [KIND_COUNT-1:0]  seen_mask,
	output logic [OUT_COUNT_W-1:0] good_count,
	output logic [OUT_COUNT_W-1:0] unsupported_count,
	output logic [OUT_COUNT_W-1:0] bad_sum_count
);

	localparam logic [FILL_W-1:0]       FILL_FULL = FILL_W'(FRAME_LEN);
	localparam logic [FILL_W-1:0]       FILL_LAST = FILL_W'(FRAME_LEN - 1);
	localparam logic [IDX_W-1:0]        SUM_LAST  = IDX_W'(FRAME_LEN - 2);
	localparam logic [COUNTER_BITS-1:0] CNT_ONE   = COUNTER_BITS'(1);

	logic [7:0]              store_q [FRAME_LEN];
	logic [FILL_W-1:0]       fill_q;
	logic [IDX_W-1:0]        idx_q;
	logic [7:0]              sum_q;
	logic [KIND_COUNT-1:0]   seen_q;
	logic [COUNTER_BITS-1:0] ok_q, odd_q, bad_q;
	logic                    out_valid_q;

	logic [8:0]              type_diff;
	logic                    type_match;
	logic [2:0]              kind_w;
	logic [KIND_COUNT-1:0]   seen_next;
	logic [COUNTER_BITS-1:0] ok_inc, odd_inc, bad_inc;

	assign type_diff  = {1'b0, store_q[1]} - {1'b0, type_base};
	assign type_match = !type_diff[8] && (type_diff[7:0] < 8'(KIND_COUNT));
	assign kind_w     = type_match ? type_diff[2:0] : 3'd0;
	assign seen_next  = seen_q | (KIND_COUNT'(1) << kind_w);

	// Counter increments wrap at the counter width before they reach the outputs.
	assign ok_inc  = ok_q + CNT_ONE;
	assign odd_inc = odd_q + CNT_ONE;
	assign bad_inc = bad_q + CNT_ONE;

	assign stat.completes  = (fill_q == FILL_LAST);
	assign stat.sum_last   = (idx_q == SUM_LAST);
	assign stat.out_free   = !out_valid_q || !out_stall;
	assign stat.bad_sum    = (sum_q != store_q[FRAME_LEN-1]);
	assign stat.shift_done = (fill_q != FILL_FULL)
		&& ((fill_q == '0) || (store_q[0] == header_byte));

	// Frame buffer: filled a byte at a time, shifted down one place per
	// cycle while realigning after a checksum error.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (fill_q == '0) begin
				store_q[0] <= rx_byte;
			end else begin
				store_q[fill_q[IDX_W-1:0]] <= rx_byte;
			end
		end else if (cmd.shift) begin
			for (int i = 0; i < FRAME_LEN - 1; i++) begin
				store_q[i] <= store_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q  <= '0;
			sum_q  <= '0;
		end else begin
			if (cmd.accept) begin
				if (fill_q == '0) begin
					if (rx_byte == header_byte) begin
						fill_q <= FILL_W'(1);
					end
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
				idx_q <= '0;
				sum_q <= '0;
			end else if (cmd.sum_step) begin
				sum_q <= sum_q + store_q[idx_q];
				idx_q <= idx_q + IDX_W'(1);
			end else if (cmd.decide && !stat.bad_sum) begin
				fill_q <= '0;
			end else if (cmd.shift) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			ok_q        <= '0;
			odd_q       <= '0;
			bad_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.decide) begin
				out_valid_q <= 1'b1;
				if (stat.bad_sum) begin
					bad_q <= bad_inc;
				end else if (type_match) begin
					ok_q   <= ok_inc;
					seen_q <= seen_next;
				end else begin
					odd_q <= odd_inc;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			type_byte  <= store_q[1];
			word_x     <= {store_q[3], store_q[2]};
			word_y     <= {store_q[5], store_q[4]};
			word_z     <= {store_q[7], store_q[6]};
			word_extra <= {store_q[9], store_q[8]};
			if (stat.bad_sum) begin
				status            <= STATUS_BAD_SUM;
				frame_kind        <= 3'd0;
				seen_mask         <= seen_q;
				good_count        <= OUT_COUNT_W'(ok_q);
				unsupported_count <= OUT_COUNT_W'(odd_q);
				bad_sum_count     <= OUT_COUNT_W'(bad_inc);
			end else if (type_match) begin
				status            <= STATUS_DECODED;
				frame_kind        <= kind_w;
				seen_mask         <= seen_next;
				good_count        <= OUT_COUNT_W'(ok_inc);
				unsupported_count <= OUT_COUNT_W'(odd_q);
				bad_sum_count     <= OUT_COUNT_W'(bad_q);
			end else begin
				status            <= STATUS_UNSUPPORTED;
				frame_kind        <= 3'd0;
				seen_mask         <= seen_q;
				good_count        <= OUT_COUNT_W'(ok_q);
				unsupported_count <= OUT_COUNT_W'(odd_inc);
				bad_sum_count     <= OUT_COUNT_W'(bad_q);
			end
		end
	end

	assign out_valid = out_valid_q;

	`IFP_ASSERT_ALWAYS(a_fill_range, fill_q <= FILL_FULL)
	`IFP_ASSERT_IMPLY(a_accept_not_full, cmd.accept, fill_q != FILL_FULL)
	`IFP_ASSERT_IMPLY(a_decide_full, cmd.decide, fill_q == FILL_FULL && stat.out_free)
	`IFP_ASSERT_NEXT(a_good_empties, cmd.decide && !stat.bad_sum, fill_q == '0 && out_valid_q)

endmodule

// File: tb/sv/imu_frame_checker.sv
`timescale 1ns / 1ps

module imu_frame_checker
	import ifp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	input  logic [31:0]            prdata,
	input  logic                   pready,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [7:0]             rx_byte,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [1:0]             status,
	input  logic [7:0]             type_byte,
	input  logic [2:0]             frame_kind,
	input  logic [15:0]            word_x,
	input  logic [15:0]            word_y,
	input  logic [15:0]            word_z,
	input  logic [15:0]            word_extra,
	input  logic [KIND_COUNT-1:0]  seen_mask,
	input  logic [OUT_COUNT_W-1:0] good_count,
	input  logic [OUT_COUNT_W-1:0] unsupported_count,
	input  logic [OUT_COUNT_W-1:0] bad_sum_count,
	output int                     frames_due_count,
	output int                     mismatches,
	output int                     decoded_total,
	output int                     unsupported_total,
	output int                     bad_sum_total
);

	localparam int PRINT_CAP = 40;

	typedef struct {
		status_code_t           status;
		logic [7:0]             type_byte;
		logic [2:0]             kind;
		logic [15:0]            word_x;
		logic [15:0]            word_y;
		logic [15:0]            word_z;
		logic [15:0]            word_extra;
		logic [KIND_COUNT-1:0]  mask;
		logic [OUT_COUNT_W-1:0] good;
		logic [OUT_COUNT_W-1:0] odd;
		logic [OUT_COUNT_W-1:0] bad;
	} frame_result_t;

	logic [7:0]             header_cfg;
	logic [7:0]             type_base_cfg;
	logic [7:0]             frame_buf [FRAME_LEN];
	int                     fill;
	logic [KIND_COUNT-1:0]  kinds_seen;
	logic [OUT_COUNT_W-1:0] ok_cnt;
	logic [OUT_COUNT_W-1:0] odd_cnt;
	logic [OUT_COUNT_W-1:0] err_cnt;
	frame_result_t          frames_due [$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t ns: mismatch on %s, got 0x%0h, expected 0x%0h",
				$realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Takes one accepted byte into the model buffer; a completing byte yields a result.
	task automatic absorb_byte(input logic [7:0] b, output bit produced,
			output frame_result_t r);
		logic [7:0] sum;
		int         i;
		int         delta;
		int         first_hdr;
		produced = 1'b0;
		if (fill == 0) begin
			if (b == header_cfg) begin
				frame_buf[0] = b;
				fill = 1;
			end
		end else begin
			frame_buf[fill] = b;
			fill++;
			if (fill == FRAME_LEN) begin
				produced = 1'b1;
				sum = '0;
				for (i = 0; i < FRAME_LEN - 1; i++)
					sum += frame_buf[i];
				r.type_byte  = frame_buf[1];
				r.word_x     = {frame_buf[3], frame_buf[2]};
				r.word_y     = {frame_buf[5], frame_buf[4]};
				r.word_z     = {frame_buf[7], frame_buf[6]};
				r.word_extra = {frame_buf[9], frame_buf[8]};
				r.kind       = '0;
				if (sum == frame_buf[FRAME_LEN - 1]) begin
					delta = int'(frame_buf[1]) - int'(type_base_cfg);
					if (delta >= 0 && delta < KIND_COUNT) begin
						r.kind = 3'(delta);
						kinds_seen[delta] = 1'b1;
						ok_cnt++;
						r.status = STATUS_DECODED;
					end else begin
						odd_cnt++;
						r.status = STATUS_UNSUPPORTED;
					end
					fill = 0;
				end else begin
					err_cnt++;
					r.status = STATUS_BAD_SUM;
					// Slide the buffer down to the first header byte after the front.
					first_hdr = 0;
					for (i = 1; i < FRAME_LEN; i++)
						if (first_hdr == 0 && frame_buf[i] == header_cfg)
							first_hdr = i;
					if (first_hdr == 0) begin
						fill = 0;
					end else begin
						for (i = 0; i < FRAME_LEN - first_hdr; i++)
							frame_buf[i] = frame_buf[i + first_hdr];
						fill = FRAME_LEN - first_hdr;
					end
				end
				r.mask = kinds_seen;
				r.good = ok_cnt;
				r.odd  = odd_cnt;
				r.bad  = err_cnt;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t fresh;
		frame_result_t want;
		bit            produced;
		if (!arst_n) begin
			header_cfg    = HEADER_RESET;
			type_base_cfg = TYPE_BASE_RESET;
			fill          = 0;
			kinds_seen    = '0;
			ok_cnt        = '0;
			odd_cnt       = '0;
			err_cnt       = '0;
			foreach (frame_buf[i])
				frame_buf[i] = '0;
			frames_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (frames_due.size() == 0) begin
					report_mismatch("result with no frame pending", type_byte, '0);
				end else begin
					want = frames_due.pop_front();
					check_field("status", status, want.status);
					check_field("type_byte", type_byte, want.type_byte);
					check_field("frame_kind", frame_kind, want.kind);
					check_field("word_x", word_x, want.word_x);
					check_field("word_y", word_y, want.word_y);
					check_field("word_z", word_z, want.word_z);
					check_field("word_extra", word_extra, want.word_extra);
					check_field("seen_mask", seen_mask, want.mask);
					check_field("good_count", good_count, want.good);
					check_field("unsupported_count", unsupported_count, want.odd);
					check_field("bad_sum_count", bad_sum_count, want.bad);
					case (want.status)
						STATUS_DECODED:     decoded_total++;
						STATUS_UNSUPPORTED: unsupported_total++;
						default:            bad_sum_total++;
					endcase
				end
			end
			if (in_valid && !in_stall) begin
				absorb_byte(rx_byte, produced, fresh);
				if (produced)
					frames_due.push_back(fresh);
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_HEADER)
						header_cfg = pwdata[7:0];
					else
						type_base_cfg = pwdata[7:0];
				end else if (paddr[2] == REG_HEADER) begin
					check_field("header register read", prdata, {24'h0, header_cfg});
				end else begin
					check_field("type base register read", prdata, {24'h0, type_base_cfg});
				end
			end
		end
		frames_due_count <= frames_due.size();
	end

endmodule

// File: tb/sv/tb_imu_frame_parser_with_resync.sv
`timescale 1ns / 1ps

module tb_imu_frame_parser_with_resync
	import ifp_pkg::*;
();

	// Hard ceiling on the run, several times the slowest legal run of this stimulus.
	localparam int LIMIT_CYCLES = 1_000_000;
	// Cycles allowed after the last result for a realignment shift to finish.
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES       = 5;
	localparam int PHASE_BYTES  = 360;

	localparam logic [2:0] ADDR_HEADER    = {REG_HEADER, 2'b00};
	localparam logic [2:0] ADDR_TYPE_BASE = {REG_TYPE_BASE, 2'b00};
	localparam logic [7:0] TYPE_BASE_MAX  = 8'd251;

	typedef logic [FRAME_LEN-1:0][7:0] frame_t;
	typedef enum {PAY_RANDOM, PAY_ZERO, PAY_ONES, PAY_HEADERS} payload_mode_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   psel      = 1'b0;
	logic                   penable   = 1'b0;
	logic                   pwrite    = 1'b0;
	logic [2:0]             paddr     = '0;
	logic [31:0]            pwdata    = '0;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic [7:0]             rx_byte   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [1:0]             status;
	logic [7:0]             type_byte;
	logic [2:0]             frame_kind;
	logic [15:0]            word_x;
	logic [15:0]            word_y;
	logic [15:0]            word_z;
	logic [15:0]            word_extra;
	logic [KIND_COUNT-1:0]  seen_mask;
	logic [OUT_COUNT_W-1:0] good_count;
	logic [OUT_COUNT_W-1:0] unsupported_count;
	logic [OUT_COUNT_W-1:0] bad_sum_count;

	int frames_due_count;
	int mismatches;
	int decoded_total;
	int unsupported_total;
	int bad_sum_total;

	// The stimulus keeps its own note of the register values it has written,
	// so that frames can be built around the current header and type base.
	logic [7:0] header_q    = HEADER_RESET;
	logic [7:0] type_base_q = TYPE_BASE_RESET;
	// When set, neither side of the data path idles: requests go back to back.
	logic       quiet       = 1'b0;
	int         bytes_sent  = 0;
	int         phase_bytes = 0;
	int         stall_hold  = 0;
	int         cycle_count = 0;

	imu_frame_parser_with_resync dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.type_byte        (type_byte),
		.frame_kind       (frame_kind),
		.word_x           (word_x),
		.word_y           (word_y),
		.word_z           (word_z),
		.word_extra       (word_extra),
		.seen_mask        (seen_mask),
		.good_count       (good_count),
		.unsupported_count(unsupported_count),
		.bad_sum_count    (bad_sum_count)
	);

	// The checker watches both channels and the register port, predicts every
	// result and compares it; its failure count, backlog and status totals come back here.
	imu_frame_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.type_byte        (type_byte),
		.frame_kind       (frame_kind),
		.word_x           (word_x),
		.word_y           (word_y),
		.word_z           (word_z),
		.word_extra       (word_extra),
		.seen_mask        (seen_mask),
		.good_count       (good_count),
		.unsupported_count(unsupported_count),
		.bad_sum_count    (bad_sum_count),
		.frames_due_count (frames_due_count),
		.mismatches       (mismatches),
		.decoded_total    (decoded_total),
		.unsupported_total(unsupported_total),
		.bad_sum_total    (bad_sum_total)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding.",
			cycle_count, frames_due_count);
		$display("[FAIL] regression broken");
		$finish;
	end

	// The receiver stalls in runs: mostly free, short stalls often and a long
	// one now and then, so that results pile up behind the output register.
	always @(posedge clk) begin
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				out_stall  <= 1'b0;
				stall_hold <= $urandom_range(0, 6);
			end else if (pick < 95) begin
				out_stall  <= 1'b1;
				stall_hold <= $urandom_range(0, 3);
			end else begin
				out_stall  <= 1'b1;
				stall_hold <= $urandom_range(10, 60);
			end
		end
	end

	// Idle cycles after a request: usually none, sometimes a few, rarely many.
	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (quiet || pick < 50)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] any_but_header();
		logic [7:0] v;
		do
			v = 8'($urandom);
		while (v == header_q);
		return v;
	endfunction

	function automatic logic [7:0] checksum_of(frame_t f);
		logic [7:0] sum;
		sum = '0;
		for (int i = 0; i < FRAME_LEN - 1; i++)
			sum += f[i];
		return sum;
	endfunction

	// A well-formed frame: header, type, eight payload bytes and a good sum.
	function automatic frame_t build_frame(logic [7:0] kind_type, payload_mode_t mode);
		frame_t f;
		f[0] = header_q;
		f[1] = kind_type;
		for (int i = 2; i < FRAME_LEN - 1; i++) begin
			case (mode)
				PAY_ZERO:    f[i] = 8'h00;
				PAY_ONES:    f[i] = 8'hFF;
				PAY_HEADERS: f[i] = header_q;
				default:     f[i] = ($urandom_range(0, 9) == 0) ? header_q : 8'($urandom);
			endcase
		end
		f[FRAME_LEN-1] = checksum_of(f);
		return f;
	endfunction

	// One request on the input channel; valid stays up across back-to-back bytes.
	task automatic push_byte(input logic [7:0] b);
		int gap;
		rx_byte  <= b;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
		phase_bytes++;
		gap = gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic push_bytes(input frame_t f, input int first, input int last);
		for (int i = first; i <= last; i++)
			push_byte(f[i]);
	endtask

	task automatic send_frame(input logic [7:0] kind_type, input bit corrupt,
			input payload_mode_t mode);
		frame_t f;
		f = build_frame(kind_type, mode);
		if (corrupt)
			f[FRAME_LEN-1] = f[FRAME_LEN-1] + 8'($urandom_range(1, 255));
		push_bytes(f, 0, FRAME_LEN - 1);
	endtask

	// A broken frame whose back half is the front of a good one: the checksum
	// error must realign onto the inner header and the good frame must decode.
	task automatic send_spliced();
		frame_t outer;
		frame_t inner;
		inner = build_frame(type_base_q + 8'($urandom_range(0, KIND_COUNT - 1)), PAY_RANDOM);
		outer[0] = header_q;
		for (int i = 1; i < 5; i++)
			outer[i] = any_but_header();
		for (int i = 5; i < FRAME_LEN; i++)
			outer[i] = inner[i - 5];
		while (checksum_of(outer) == outer[FRAME_LEN-1] || outer[4] == header_q)
			outer[4] = outer[4] + 8'd1;
		push_bytes(outer, 0, FRAME_LEN - 1);
		push_bytes(inner, 6, FRAME_LEN - 1);
	endtask

	// A header and a few bytes, then a full frame whose header lands mid-frame.
	task automatic send_truncated();
		int k;
		k = $urandom_range(1, FRAME_LEN - 2);
		push_byte(header_q);
		repeat (k) push_byte(8'($urandom));
		send_frame(type_base_q + 8'($urandom_range(0, KIND_COUNT - 1)), 1'b0, PAY_RANDOM);
	endtask

	task automatic apb_access(input logic [2:0] addr, input bit write,
			input logic [7:0] val);
		logic [31:0] noise;
		noise = $urandom;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= {noise[31:8], val};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
	endtask

	task automatic apb_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Stop sending and wait for every predicted result, then let any trailing
	// realignment shift finish so that the block is idle for register writes.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (frames_due_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic directed_frames();
		// Bytes with an empty buffer are dropped unless they are the header.
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(header_q - 8'd1);
		// Every kind once, with all-zero, all-one and all-header payloads.
		send_frame(type_base_q,        1'b0, PAY_ZERO);
		send_frame(type_base_q + 8'd1, 1'b0, PAY_ONES);
		send_frame(type_base_q + 8'd2, 1'b0, PAY_HEADERS);
		send_frame(type_base_q + 8'd3, 1'b0, PAY_RANDOM);
		send_frame(type_base_q + 8'd4, 1'b0, PAY_RANDOM);
		// Type bytes just outside the kind range, and the extreme type values.
		send_frame(type_base_q - 8'd1, 1'b0, PAY_RANDOM);
		send_frame(type_base_q + 8'd5, 1'b0, PAY_RANDOM);
		send_frame(8'h00, 1'b0, PAY_ONES);
		send_frame(8'hFF, 1'b0, PAY_ZERO);
		// A bad sum with no header inside empties the buffer; with one it realigns.
		send_frame(type_base_q, 1'b1, PAY_ZERO);
		send_spliced();
		send_truncated();
	endtask

	task automatic random_frames();
		int pick;
		payload_mode_t mode;
		while (phase_bytes < PHASE_BYTES) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 19))
				0:       mode = PAY_ZERO;
				1:       mode = PAY_ONES;
				2:       mode = PAY_HEADERS;
				default: mode = PAY_RANDOM;
			endcase
			if (pick < 60)
				send_frame(type_base_q + 8'($urandom_range(0, KIND_COUNT - 1)), 1'b0, mode);
			else if (pick < 70)
				send_frame(8'($urandom), 1'b0, mode);
			else if (pick < 80)
				send_frame(8'($urandom), 1'b1, mode);
			else if (pick < 88)
				send_spliced();
			else if (pick < 95)
				send_truncated();
			else
				repeat ($urandom_range(1, 6)) push_byte(any_but_header());
		end
	endtask

	initial begin
		logic [7:0] next_header;
		logic [7:0] next_base;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			phase_bytes = 0;
			// The first setting is the reset one; the rest hit both extremes
			// and then random values, always with the block idle.
			if (p != 0) begin
				case (p)
					1: begin
						next_header = 8'h00;
						next_base   = 8'h00;
					end
					2: begin
						next_header = 8'hFF;
						next_base   = TYPE_BASE_MAX;
					end
					default: begin
						next_header = 8'($urandom);
						next_base   = 8'($urandom_range(0, TYPE_BASE_MAX));
					end
				endcase
				apb_access(ADDR_HEADER, 1'b1, next_header);
				apb_access(ADDR_TYPE_BASE, 1'b1, next_base);
				header_q    = next_header;
				type_base_q = next_base;
			end
			apb_access(ADDR_HEADER, 1'b0, 8'h00);
			apb_access(ADDR_TYPE_BASE, 1'b0, 8'h00);
			apb_release();
			quiet <= (p == 2);
			if (p == 0)
				directed_frames();
			random_frames();
			settle();
		end

		$display("Drove %0d bytes through %0d register settings, extremes included,",
			bytes_sent, PHASES);
		$display("checking %0d decoded, %0d unsupported and %0d checksum-error frames.",
			decoded_total, unsupported_total, bad_sum_total);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
